// ----- hw/rtl/iban_format_and_mod97_check_defines.svh -----
// Assertion macros for the IBAN check block
`ifndef IBAN_FORMAT_AND_MOD97_CHECK_DEFINES_SVH
`define IBAN_FORMAT_AND_MOD97_CHECK_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define IBAN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define IBAN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/iban_pkg.sv -----
// Types, constants and helper functions shared by the IBAN check block
package iban_pkg;

  localparam int unsigned MODULUS = 97;
  localparam int unsigned REM_W   = 7;

  localparam logic [7:0] CH_P          = 8'h50;
  localparam logic [7:0] CH_L          = 8'h4C;
  localparam logic [7:0] CH_D          = 8'h44;
  localparam logic [7:0] CH_E          = 8'h45;
  localparam logic [7:0] CH_C          = 8'h43;
  localparam logic [7:0] CH_Y          = 8'h59;
  localparam logic [7:0] CH_ZERO       = 8'd48;
  localparam logic [7:0] CH_NINE       = 8'd57;
  localparam logic [7:0] CH_UPPER_A    = 8'd65;
  localparam logic [7:0] CH_UPPER_Z    = 8'd90;
  localparam logic [7:0] LETTER_OFFSET = 8'd55;

  localparam logic [6:0] LEN_PL = 7'd28;
  localparam logic [6:0] LEN_DE = 7'd22;
  localparam logic [6:0] LEN_CY = 7'd28;

  localparam logic [5:0] POS_MAX      = 6'd63;
  localparam logic [5:0] POS_COUNTRY  = 6'd2;
  localparam logic [5:0] POS_PREFIX   = 6'd4;
  localparam logic [5:0] CY_DIGIT_END = 6'd12;

  typedef logic [REM_W-1:0] rem_t;
  typedef logic [7:0]       char_t;
  typedef logic [3:0]       digit_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_PL   = 2'd1,
    KIND_DE   = 2'd2,
    KIND_CY   = 2'd3
  } country_e;

  typedef rem_t rem_lut_t [MODULUS];

  // Build (10 * r) mod 97 by stepping 10 at a time, wrapping once per step
  function automatic rem_lut_t build_mul10_lut();
    rem_lut_t    lut;
    int unsigned acc;
    acc = 0;
    for (int unsigned i = 0; i < MODULUS; i++) begin
      lut[i] = rem_t'(acc);
      acc    = acc + 10;
      if (acc >= MODULUS) acc = acc - MODULUS;
    end
    return lut;
  endfunction

  localparam rem_lut_t MUL10_LUT = build_mul10_lut();

  function automatic logic is_digit(input char_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_upper(input char_t c);
    return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
  endfunction

endpackage

// ----- hw/rtl/iban_char_if.sv -----
// Input channel: one IBAN character per item with a final-character flag
interface iban_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// ----- hw/rtl/iban_result_if.sv -----
// Result channel: one verdict per IBAN
interface iban_result_if;
  logic valid;
  logic ready;
  logic iban_valid;

  modport source (output valid, output iban_valid, input ready);
  modport sink   (input valid, input iban_valid, output ready);
endinterface

// ----- hw/rtl/iban_fold_unit.sv -----
// Shared mod-97 step: remainder times ten plus one decimal digit, reduced
module iban_fold_unit
  import iban_pkg::*;
(
  input  rem_t   rem_i,
  input  digit_t digit_i,
  output rem_t   rem_o
);

  logic [7:0] sum;
  rem_t       scaled;

  // Remainder never reaches the modulus, so the table index stays in range
  always_comb begin
    scaled = '0;
    if (rem_i < rem_t'(MODULUS)) scaled = MUL10_LUT[rem_i];
  end

  // Sum stays below twice the modulus: one conditional subtract suffices
  assign sum   = {1'b0, scaled} + {4'b0, digit_i};
  assign rem_o = (sum >= 8'(MODULUS)) ? rem_t'(sum - 8'(MODULUS)) : rem_t'(sum);

endmodule

// ----- hw/rtl/iban_format_and_mod97_check.sv -----
// IBAN format and mod-97 check, one character per input item. Characters
// arrive in order with is_last on the final one; a single verdict item is
// issued per IBAN (1 when the country is PL, DE or CY, length and character
// classes are right and the mod-97 remainder is 1). Every character passes
// through one shared mod-97 digit step. Each of the first four characters is
// format-checked and held when accepted; a later character is accepted and
// then folded at one step per decimal place (a letter has two, a digit one),
// or takes one step to flag a character that is neither digit nor letter.
// The final character then folds in the four held characters at one step per
// decimal place or flagged character, and the end step loads the result
// register, held there while an earlier verdict waits. The input is not ready
// while the step unit is busy or the end step waits; the result register lets
// the next IBAN start while a verdict waits to be taken.
`include "iban_format_and_mod97_check_defines.svh"

module iban_format_and_mod97_check
  import iban_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  iban_char_if.sink          in_i,
  iban_result_if.source      out_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FOLD = 2'd1;
  localparam logic [1:0] S_END  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [5:0] pos_q, pos_d;
  char_t      held_q [4];
  char_t      held_d [4];
  rem_t       rem_q, rem_d;
  logic       fail_q, fail_d;
  country_e   kind_q, kind_d;
  char_t      ch_q, ch_d;
  logic       last_q, last_d;
  logic       pre_q, pre_d;
  logic [1:0] idx_q, idx_d;
  logic       hi_done_q, hi_done_d;
  logic       out_valid_q, out_valid_d;
  logic       out_bit_q, out_bit_d;

  logic       in_fire;
  logic       cur_digit, cur_upper;
  char_t      letter_val;
  digit_t     tens, units;
  char_t      units_full;
  digit_t     step_digit;
  rem_t       rem_step;

  // Accept-path scratch
  char_t      c;
  logic       need_digit;
  logic [6:0] need_len;
  logic [6:0] total_len;
  logic       char_done;

  assign in_i.ready       = (state_q == S_IDLE);
  assign in_fire          = in_i.valid && in_i.ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.iban_valid = out_bit_q;

  // Split the character being folded into decimal places
  assign cur_digit  = is_digit(ch_q);
  assign cur_upper  = is_upper(ch_q);
  assign letter_val = ch_q - LETTER_OFFSET;

  always_comb begin
    if (letter_val >= 8'd30)      tens = 4'd3;
    else if (letter_val >= 8'd20) tens = 4'd2;
    else                          tens = 4'd1;
  end

  assign units_full = letter_val - {4'b0, tens} * 8'd10;
  assign units      = units_full[3:0];

  always_comb begin
    if (cur_digit)       step_digit = digit_t'(ch_q - CH_ZERO);
    else if (!hi_done_q) step_digit = tens;
    else                 step_digit = units;
  end

  iban_fold_unit u_fold (
    .rem_i   (rem_q),
    .digit_i (step_digit),
    .rem_o   (rem_step)
  );

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    held_d      = held_q;
    rem_d       = rem_q;
    fail_d      = fail_q;
    kind_d      = kind_q;
    ch_d        = ch_q;
    last_d      = last_q;
    pre_d       = pre_q;
    idx_d       = idx_q;
    hi_done_d   = hi_done_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_bit_d   = out_bit_q;
    c           = in_i.char_code;
    need_digit  = 1'b0;
    need_len    = '0;
    total_len   = {1'b0, pos_q} + 7'd1;
    char_done   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          // Format checks on the incoming character
          if (pos_q < POS_COUNTRY) begin
            if (!is_upper(c)) fail_d = 1'b1;
            if (pos_q == 6'd1) begin
              if (held_q[0] == CH_P && c == CH_L)      kind_d = KIND_PL;
              else if (held_q[0] == CH_D && c == CH_E) kind_d = KIND_DE;
              else if (held_q[0] == CH_C && c == CH_Y) kind_d = KIND_CY;
              else begin
                kind_d = KIND_NONE;
                fail_d = 1'b1;
              end
            end
          end else begin
            need_digit = (kind_q == KIND_PL) || (kind_q == KIND_DE) ||
                         ((kind_q == KIND_CY) && (pos_q < CY_DIGIT_END));
            if (need_digit && !is_digit(c)) fail_d = 1'b1;
          end

          if (pos_q < POS_PREFIX) held_d[pos_q[1:0]] = c;
          if (pos_q != POS_MAX) pos_d = pos_q + 6'd1;

          case (kind_d)
            KIND_PL: need_len = LEN_PL;
            KIND_DE: need_len = LEN_DE;
            KIND_CY: need_len = LEN_CY;
            default: need_len = '0;
          endcase
          if (in_i.is_last && (kind_d == KIND_NONE || total_len != need_len)) begin
            fail_d = 1'b1;
          end

          last_d    = in_i.is_last;
          hi_done_d = 1'b0;
          idx_d     = '0;
          if (pos_q >= POS_PREFIX) begin
            ch_d    = c;
            pre_d   = 1'b0;
            state_d = S_FOLD;
          end else if (in_i.is_last) begin
            // Go straight to folding the held prefix
            ch_d    = held_d[0];
            pre_d   = 1'b1;
            state_d = S_FOLD;
          end
        end
      end

      S_FOLD: begin
        if (cur_digit) begin
          rem_d     = rem_step;
          char_done = 1'b1;
        end else if (cur_upper) begin
          rem_d = rem_step;
          if (!hi_done_q) hi_done_d = 1'b1;
          else            char_done = 1'b1;
        end else begin
          fail_d    = 1'b1;
          char_done = 1'b1;
        end

        if (char_done) begin
          hi_done_d = 1'b0;
          if (pre_q) begin
            if (idx_q == 2'd3) begin
              state_d = S_END;
            end else begin
              idx_d = idx_q + 2'd1;
              ch_d  = held_q[idx_q + 2'd1];
            end
          end else if (last_q) begin
            pre_d = 1'b1;
            idx_d = '0;
            ch_d  = held_q[0];
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      S_END: begin
        // Hold until the result register is free, then start afresh
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_bit_d   = !fail_q && (rem_q == rem_t'(1));
          pos_d       = '0;
          for (int i = 0; i < 4; i++) held_d[i] = '0;
          rem_d       = '0;
          fail_d      = 1'b0;
          kind_d      = KIND_NONE;
          pre_d       = 1'b0;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      for (int i = 0; i < 4; i++) held_q[i] <= '0;
      rem_q       <= '0;
      fail_q      <= 1'b0;
      kind_q      <= KIND_NONE;
      last_q      <= 1'b0;
      pre_q       <= 1'b0;
      idx_q       <= '0;
      hi_done_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      held_q      <= held_d;
      rem_q       <= rem_d;
      fail_q      <= fail_d;
      kind_q      <= kind_d;
      last_q      <= last_d;
      pre_q       <= pre_d;
      idx_q       <= idx_d;
      hi_done_q   <= hi_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q      <= ch_d;
    out_bit_q <= out_bit_d;
  end

  `IBAN_ASSERT_NEXT(a_last_starts_fold, in_fire && in_i.is_last, state_q == S_FOLD, "final item did not start the fold")
  `IBAN_ASSERT_NOW(a_result_from_end, $rose(out_valid_q), $past(state_q) == S_END && pos_q == '0 && rem_q == '0, "result issued outside the end step")
  `IBAN_ASSERT_NOW(a_rem_in_range, state_q == S_FOLD, rem_q < rem_t'(MODULUS), "remainder out of range")

endmodule
